// ===== src/scld_pkg.sv =====
package scld_pkg;

	localparam int STRIPE_COUNT       = 5;
	localparam int STRIPE_HALF_HEIGHT = 2;
	localparam int COORD_BITS         = 12;

	localparam int STRIPE_IDX_BITS = (STRIPE_COUNT > 1) ? $clog2(STRIPE_COUNT) : 1;

	localparam int PIXEL_BITS = 8;
	localparam int CFG_BITS   = 12;
	localparam int REG_IDX_BITS = 2;

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

	localparam reg_idx_t REG_FRAME_WIDTH  = reg_idx_t'(0);
	localparam reg_idx_t REG_FRAME_HEIGHT = reg_idx_t'(1);

	localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RESET  = CFG_BITS'(160);
	localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = CFG_BITS'(240);

	localparam int COL_LOW  = 40;
	localparam int COL_HIGH = 100;

	localparam int CENTRE_ROW [8] = '{60, 85, 110, 135, 160, 185, 210, 235};
	localparam int LIMIT_OF   [8] = '{110, 100, 110, 100, 110, 100, 110, 100};
	localparam int HEAD_OF    [8] = '{8, 7, 6, 5, 4, 3, 2, 1};

	localparam int MIN_WIDTH  = COL_HIGH + 1;
	localparam int MIN_HEIGHT = CENTRE_ROW[STRIPE_COUNT-1] + STRIPE_HALF_HEIGHT + 2;

	// floor(n / 150) == (n * CONF_RECIP) >> CONF_SHIFT for n < 2^16
	localparam int CONF_SHIFT = 24;
	localparam logic [16:0] CONF_RECIP = 17'd111849;
	localparam logic [15:0] CONF_ROUND = 16'd75;
	localparam logic [8:0] CONF_MIN = 9'd26;
	localparam logic [8:0] CONF_MAX = 9'd256;

endpackage

// ===== src/scld_if.sv =====
interface scld_pixel_if;
	logic                   valid;
	logic                   ready;
	logic [7:0]             pixel_value;
	logic                   frame_start;

	modport source (output valid, output pixel_value, output frame_start, input ready);
	modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface scld_reading_if;
	logic       valid;
	logic       ready;
	logic       reading_valid;
	logic [3:0] head_hundredths;
	logic [7:0] level_row;
	logic [8:0] confidence_q8;

	modport source (output valid, output reading_valid, output head_hundredths,
		output level_row, output confidence_q8, input ready);
	modport sink   (input valid, input reading_valid, input head_hundredths,
		input level_row, input confidence_q8, output ready);
endinterface

interface scld_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [scld_pkg::REG_IDX_BITS-1:0]   reg_index;
	logic [scld_pkg::CFG_BITS-1:0]       data;

	modport source (output valid, output reg_index, output data, input ready);
	modport sink   (input valid, input reg_index, input data, output ready);
endinterface

// ===== src/stripe_contrast_level_detector.sv =====
// channel   dir  handshake     payload
// pixels    in   valid/ready   pixel_value[7:0], frame_start
// readings  out  valid/ready   reading_valid, head_hundredths[3:0],
//                              level_row[7:0], confidence_q8[8:0]
// cfg       in   valid/ready   reg_index[1:0], data[11:0]
//
// One pixel per cycle unless a reading waits: input register, then min/max
// update, counters and the reading (one 16x17 multiply) in a single pass into the
// output register, which offers the frame's reading. cfg is always ready.
// Reset (arst_n low) clears counters and stripe store, loads the default frame size.
// A waiting reading holds the pixel stage; pixels stall only then.
module stripe_contrast_level_detector (
	input logic clk,
	input logic arst_n,
	scld_pixel_if.sink     pixels,
	scld_reading_if.source readings,
	scld_cfg_if.sink       cfg
);

	localparam int N = scld_pkg::STRIPE_COUNT;
	localparam int CB = scld_pkg::COORD_BITS;

	logic [scld_pkg::CFG_BITS-1:0] frame_width_q, frame_height_q;

	logic                 valid_s1;
	scld_pkg::pixel_t     pixel_s1;
	logic                 fs_s1;
	logic                 advance;

	scld_pkg::coord_t     col_q, row_q;
	scld_pkg::pixel_t     min_q [N];
	scld_pkg::pixel_t     max_q [N];

	scld_pkg::coord_t     col_eff, row_eff;
	scld_pkg::pixel_t     min_new [N];
	scld_pkg::pixel_t     max_new [N];
	logic                 col_in;
	logic                 row_end, frame_end;
	logic [7:0]           contrast [N];
	logic [scld_pkg::STRIPE_IDX_BITS-1:0] pick;
	logic [7:0]           pick_contrast;
	logic [15:0]          conf_num;
	logic [32:0]          conf_prod;
	logic [8:0]           conf_raw, conf_clamped;
	logic                 size_ok;

	logic                 out_valid_q;
	logic                 rv_q;
	logic [3:0]           head_q;
	logic [7:0]           trow_q;
	logic [8:0]           conf_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= scld_pkg::FRAME_WIDTH_RESET;
			frame_height_q <= scld_pkg::FRAME_HEIGHT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				scld_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg.data;
				scld_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign advance = valid_s1 && (!out_valid_q || readings.ready);
	assign pixels.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixels.ready) begin
			valid_s1 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixels.valid && pixels.ready) begin
			pixel_s1 <= pixels.pixel_value;
			fs_s1    <= pixels.frame_start;
		end
	end

	always_comb begin
		col_eff = fs_s1 ? '0 : col_q;
		row_eff = fs_s1 ? '0 : row_q;
		col_in  = (col_eff >= CB'(scld_pkg::COL_LOW)) && (col_eff <= CB'(scld_pkg::COL_HIGH));
		row_end   = ({1'b0, col_eff} + (CB+1)'(1)) >= (CB+1)'(frame_width_q);
		frame_end = ({1'b0, row_eff} + (CB+1)'(1)) >= (CB+1)'(frame_height_q);
		for (int i = 0; i < N; i++) begin
			min_new[i] = fs_s1 ? '1 : min_q[i];
			max_new[i] = fs_s1 ? '0 : max_q[i];
			if (col_in &&
				(({1'b0, row_eff} + (CB+1)'(scld_pkg::STRIPE_HALF_HEIGHT)) >=
					(CB+1)'(scld_pkg::CENTRE_ROW[i])) &&
				({1'b0, row_eff} <= (CB+1)'(scld_pkg::CENTRE_ROW[i] +
					scld_pkg::STRIPE_HALF_HEIGHT))) begin
				if (pixel_s1 < min_new[i]) min_new[i] = pixel_s1;
				if (pixel_s1 > max_new[i]) max_new[i] = pixel_s1;
			end
			contrast[i] = (max_new[i] < min_new[i]) ? 8'd0 : (max_new[i] - min_new[i]);
		end
		// first stripe below its limit wins; last stripe is the fallback
		pick = scld_pkg::STRIPE_IDX_BITS'(N - 1);
		for (int i = N - 2; i >= 0; i--) begin
			if ({1'b0, contrast[i]} < 9'(scld_pkg::LIMIT_OF[i]))
				pick = scld_pkg::STRIPE_IDX_BITS'(i);
		end
		pick_contrast = contrast[pick];
		conf_num  = {pick_contrast, 8'd0} + scld_pkg::CONF_ROUND;
		conf_prod = 33'(conf_num) * 33'(scld_pkg::CONF_RECIP);
		conf_raw  = conf_prod[scld_pkg::CONF_SHIFT +: 9];
		if (conf_raw < scld_pkg::CONF_MIN)
			conf_clamped = scld_pkg::CONF_MIN;
		else if (conf_raw > scld_pkg::CONF_MAX)
			conf_clamped = scld_pkg::CONF_MAX;
		else
			conf_clamped = conf_raw;
		size_ok = (frame_width_q >= scld_pkg::CFG_BITS'(scld_pkg::MIN_WIDTH)) &&
			(frame_height_q >= scld_pkg::CFG_BITS'(scld_pkg::MIN_HEIGHT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < N; i++) begin
				min_q[i] <= '1;
				max_q[i] <= '0;
			end
		end else if (advance) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_eff + CB'(1);
			end else begin
				col_q <= col_eff + CB'(1);
				row_q <= row_eff;
			end
			for (int i = 0; i < N; i++) begin
				min_q[i] <= (row_end && frame_end) ? '1 : min_new[i];
				max_q[i] <= (row_end && frame_end) ? '0 : max_new[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && row_end && frame_end) begin
			out_valid_q <= 1'b1;
		end else if (readings.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && row_end && frame_end) begin
			rv_q   <= size_ok;
			head_q <= size_ok ? 4'(scld_pkg::HEAD_OF[pick]) : 4'd0;
			trow_q <= size_ok ? 8'(scld_pkg::CENTRE_ROW[pick]) : 8'd0;
			conf_q <= size_ok ? conf_clamped : 9'd0;
		end
	end

	assign readings.valid           = out_valid_q;
	assign readings.reading_valid   = rv_q;
	assign readings.head_hundredths = head_q;
	assign readings.level_row       = trow_q;
	assign readings.confidence_q8   = conf_q;

endmodule

// ===== src/scld_checker.sv =====
module scld_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       reading_valid,
	input logic [3:0] head_hundredths,
	input logic [7:0] level_row,
	input logic [8:0] confidence_q8,
	input logic       cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("reading dropped while stalled");

	a_conf_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reading_valid |->
			confidence_q8 >= 9'd26 && confidence_q8 <= 9'd256 && head_hundredths != 4'd0)
		else $error("confidence out of range");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reading_valid |->
			head_hundredths == 4'd0 && level_row == 8'd0 && confidence_q8 == 9'd0)
		else $error("invalid reading has nonzero fields");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("cfg not ready");

endmodule

bind stripe_contrast_level_detector scld_checker u_scld_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (readings.valid),
	.out_ready       (readings.ready),
	.reading_valid   (readings.reading_valid),
	.head_hundredths (readings.head_hundredths),
	.level_row       (readings.level_row),
	.confidence_q8   (readings.confidence_q8),
	.cfg_ready       (cfg.ready)
);
